// ===== hdl/ttc_pkg.sv =====
package ttc_pkg;

    localparam int DIV_W          = 32;
    localparam int CNT_W          = 6;
    localparam int NS_W           = 30;
    localparam int PROD_W         = DIV_W + NS_W;
    localparam int TICK_WIDTH_DEF = 32;

    localparam logic [NS_W-1:0]  NS_PER_SEC   = NS_W'(1000000000);
    localparam logic [DIV_W-1:0] DEFAULT_FREQ = DIV_W'(100);

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_PROCESS = 2'd1,
        STAT_BAD_CLOCK  = 2'd2,
        STAT_FAULT      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SEC,
        FS_MUL,
        FS_NS,
        FS_DONE
    } fsm_t;

    typedef struct packed {
        logic [31:0] clock_sel;
        logic [31:0] tick_count;
        logic        caller_allowed;
        logic        buffer_writable;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] seconds;
        logic [29:0] nanoseconds;
        logic [31:0] success_total;
        logic [31:0] denial_total;
        logic [31:0] fault_total;
    } out_item_t;

    typedef struct packed {
        logic             load;
        logic [DIV_W-1:0] rem_init;
        logic [DIV_W-1:0] dq_init;
        logic [CNT_W-1:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic clock_supported(input logic [31:0] id);
        return id == 32'd0 || id == 32'd1 || id == 32'd4 || id == 32'd5
            || id == 32'd6 || id == 32'd7;
    endfunction

endpackage

// ===== hdl/tick_to_timespec_clock_read.sv =====
// channel  | dir | handshake             | payload
// in       | in  | in_valid / in_stall   | in_data (clock_sel, tick_count, flags)
// out      | out | out_valid / out_stall | out_data (status, time, totals)
// cfg      | in  | cfg_wr_en             | cfg_wr_data (tick frequency)
//
// a granted read divides the ticks for seconds, a bit per cycle, waits for the
// divider's done, loads the product and divides it for nanoseconds, waits for done
// again, hands off the beat and returns to idle
// a rejected read goes straight to the hand-off; one request is worked at a time
// reset clears the counters and sets the frequency to 100
// a stalled output beat holds; the next request is taken while it waits
module tick_to_timespec_clock_read #(
    parameter int TICK_WIDTH = ttc_pkg::TICK_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ttc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ttc_pkg::out_item_t out_data,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data
);
    import ttc_pkg::*;

    localparam int EFF_W = (TICK_WIDTH < DIV_W) ? TICK_WIDTH : DIV_W;

    fsm_t              state_reg, state_next;
    logic [DIV_W-1:0]  freq_reg;
    logic [DIV_W-1:0]  divisor;
    status_t           stat_reg;
    status_t           stat_next;
    logic [31:0]       sec_reg;
    logic [NS_W-1:0]   ns_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [31:0]       succ_reg, succ_next;
    logic [31:0]       deny_reg, deny_next;
    logic [31:0]       fault_reg, fault_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg;
    logic              accept;
    logic              out_load;
    div_cmd_t          div_cmd;
    div_stat_t         div_stat;
    logic [DIV_W-1:0]  div_quot;
    logic [DIV_W-1:0]  div_rem;

    assign divisor = (freq_reg == '0) ? DEFAULT_FREQ : freq_reg;
    assign accept  = in_valid && !in_stall;

    always_comb
    begin
        if (!in_data.caller_allowed)
            stat_next = STAT_NO_PROCESS;
        else if (!clock_supported(in_data.clock_sel))
            stat_next = STAT_BAD_CLOCK;
        else if (!in_data.buffer_writable)
            stat_next = STAT_FAULT;
        else
            stat_next = STAT_OK;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (in_valid)
                    state_next = (stat_next == STAT_OK) ? FS_SEC : FS_DONE;
            end
            FS_SEC:
            begin
                if (div_stat.done)
                    state_next = FS_MUL;
            end
            FS_MUL:
                state_next = FS_NS;
            FS_NS:
            begin
                if (div_stat.done)
                    state_next = FS_DONE;
            end
            FS_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = FS_IDLE;
            end
            default:
                state_next = FS_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall         = 1'b1;
        out_load         = 1'b0;
        div_cmd.load     = 1'b0;
        div_cmd.rem_init = '0;
        div_cmd.dq_init  = in_data.tick_count << (DIV_W - EFF_W);
        div_cmd.steps    = CNT_W'(EFF_W);
        unique case (state_reg)
            FS_IDLE:
            begin
                in_stall     = 1'b0;
                div_cmd.load = in_valid && stat_next == STAT_OK;
            end
            FS_SEC:
                ;
            FS_MUL:
            begin
                div_cmd.load     = 1'b1;
                div_cmd.rem_init = prod_reg[PROD_W-1:NS_W];
                div_cmd.dq_init  = {prod_reg[NS_W-1:0], {(DIV_W-NS_W){1'b0}}};
                div_cmd.steps    = CNT_W'(NS_W);
            end
            FS_NS:
                ;
            FS_DONE:
                out_load = !out_valid_reg || !out_stall;
            default:
                ;
        endcase
    end

    always_comb
    begin
        succ_next  = succ_reg + 32'(stat_reg == STAT_OK);
        deny_next  = deny_reg + 32'(stat_reg == STAT_NO_PROCESS
                                    || stat_reg == STAT_BAD_CLOCK);
        fault_next = fault_reg + 32'(stat_reg == STAT_FAULT);
        if (out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    ttc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (div_cmd),
        .divisor (divisor),
        .stat    (div_stat),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FS_IDLE;
            freq_reg      <= DEFAULT_FREQ;
            succ_reg      <= '0;
            deny_reg      <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                freq_reg <= cfg_wr_data;
            if (out_load)
            begin
                succ_reg  <= succ_next;
                deny_reg  <= deny_next;
                fault_reg <= fault_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stat_reg <= stat_next;
            sec_reg  <= '0;
            ns_reg   <= '0;
        end
        if (state_reg == FS_SEC && div_stat.done)
        begin
            sec_reg  <= div_quot;
            prod_reg <= PROD_W'(div_rem) * PROD_W'(NS_PER_SEC);
        end
        if (state_reg == FS_NS && div_stat.done)
            ns_reg <= div_quot[NS_W-1:0];
        if (out_load)
        begin
            out_reg.status        <= stat_reg;
            out_reg.seconds       <= sec_reg;
            out_reg.nanoseconds   <= ns_reg;
            out_reg.success_total <= succ_next;
            out_reg.denial_total  <= deny_next;
            out_reg.fault_total   <= fault_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("request taken while a request is in flight");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == FS_SEC || state_reg == FS_NS))
        else $error("divider finished outside a divide phase");

    a_busy_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == FS_SEC || state_reg == FS_NS))
        else $error("divider running outside a divide phase");

    a_fail_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STAT_OK
            |-> out_data.seconds == '0 && out_data.nanoseconds == '0)
        else $error("failed read carries a time");

    a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.nanoseconds < NS_PER_SEC)
        else $error("nanoseconds out of range");

    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> $countones({succ_reg != $past(succ_reg),
                                 deny_reg != $past(deny_reg),
                                 fault_reg != $past(fault_reg)}) == 1)
        else $error("beat did not bump exactly one counter");
`endif

endmodule

// ===== hdl/ttc_div.sv =====
module ttc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ttc_pkg::div_cmd_t              cmd,
    input  logic [ttc_pkg::DIV_W-1:0]      divisor,
    output ttc_pkg::div_stat_t             stat,
    output logic [ttc_pkg::DIV_W-1:0]      quot,
    output logic [ttc_pkg::DIV_W-1:0]      rem
);
    import ttc_pkg::*;

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             qbit;

    // one restoring step: bring in the next dividend bit, try the subtract
    always_comb
    begin
        shifted = {rem_reg, dq_reg[DIV_W-1]};
        diff    = shifted - {1'b0, divisor};
        qbit    = shifted >= {1'b0, divisor};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd.load)
        begin
            rem_next = cmd.rem_init;
            dq_next  = cmd.dq_init;
            cnt_next = cmd.steps;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            dq_next   = {dq_reg[DIV_W-2:0], qbit};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = cnt_reg == CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign stat.busy = cnt_reg != '0;
    assign stat.done = done_reg;
    assign quot      = dq_reg;
    assign rem       = rem_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ttc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int QUIET_PERIOD = 25000;
    localparam int QUIET_SPAN   = 4000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    in_item_t    in_data     = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    out_item_t   out_data;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    in_item_t    pending_reqs[$];
    out_item_t   expected_reads[$];

    logic [31:0] freq_setting  = 32'd100;
    logic [31:0] granted_count = '0;
    logic [31:0] denied_count  = '0;
    logic [31:0] faulted_count = '0;

    int cycle_count = 0;
    int mismatches  = 0;
    logic quiet;

    assign quiet = (cycle_count % QUIET_PERIOD) < QUIET_SPAN;

    tick_to_timespec_clock_read i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic out_item_t predict_timespec(in_item_t req);
        out_item_t   r;
        logic [63:0] divisor;
        logic [63:0] ticks;
        logic [63:0] rem;
        logic [63:0] ns;
        r = '0;
        if (!req.caller_allowed)
        begin
            r.status = STAT_NO_PROCESS;
            denied_count = denied_count + 32'd1;
        end
        else if (!(req.clock_sel inside {32'd0, 32'd1, 32'd4, 32'd5, 32'd6, 32'd7}))
        begin
            r.status = STAT_BAD_CLOCK;
            denied_count = denied_count + 32'd1;
        end
        else if (!req.buffer_writable)
        begin
            r.status = STAT_FAULT;
            faulted_count = faulted_count + 32'd1;
        end
        else
        begin
            divisor = (freq_setting == 32'd0) ? 64'd100 : {32'd0, freq_setting};
            ticks = {32'd0, req.tick_count};
            rem = ticks % divisor;
            ns = (rem * 64'd1000000000) / divisor;
            r.status = STAT_OK;
            r.seconds = 32'(ticks / divisor);
            r.nanoseconds = ns[29:0];
            granted_count = granted_count + 32'd1;
        end
        r.success_total = granted_count;
        r.denial_total  = denied_count;
        r.fault_total   = faulted_count;
        return r;
    endfunction

    // driver: new beat only when the line is free, valid held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_reads.push_back(predict_timespec(in_data));
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 24))
                begin
                    in_data  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reads.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_reads.pop_front();
                    check_field("status", 32'(want.status), 32'(out_data.status));
                    check_field("seconds", want.seconds, out_data.seconds);
                    check_field("nanoseconds", 32'(want.nanoseconds),
                                32'(out_data.nanoseconds));
                    check_field("success_total", want.success_total,
                                out_data.success_total);
                    check_field("denial_total", want.denial_total, out_data.denial_total);
                    check_field("fault_total", want.fault_total, out_data.fault_total);
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < 24);
        end
    end

    function automatic in_item_t make_req(logic [31:0] id, logic [31:0] ticks,
                                          logic allowed, logic writable);
        in_item_t r;
        r.clock_sel       = id;
        r.tick_count      = ticks;
        r.caller_allowed  = allowed;
        r.buffer_writable = writable;
        return r;
    endfunction

    function automatic in_item_t random_req();
        logic [31:0] ids[6];
        logic [31:0] id;
        logic [31:0] ticks;
        logic [31:0] f;
        ids = '{32'd0, 32'd1, 32'd4, 32'd5, 32'd6, 32'd7};
        f = (freq_setting == 32'd0) ? 32'd100 : freq_setting;
        case ($urandom_range(9))
            0:       id = $urandom;
            1, 2:    id = $urandom_range(15);
            default: id = ids[$urandom_range(5)];
        endcase
        case ($urandom_range(4))
            0, 1:    ticks = $urandom;
            2:       ticks = $urandom_range(1000);
            3:       ticks = f * $urandom_range(50) + $urandom_range(2) - 1;
            default: ticks = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
        return make_req(id, ticks, $urandom_range(9) != 0, $urandom_range(9) != 0);
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_reads.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_frequency(logic [31:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        freq_setting  = value;
    endtask

    task automatic queue_random(int count);
        @(negedge clk);
        repeat (count)
            pending_reqs.push_back(random_req());
    endtask

    initial
    begin : timeout
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] freqs[$];
        freqs = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1000000000, 32'd32768, 32'd3,
                  32'd1000, $urandom, $urandom_range(100000, 1), 32'd100};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        // reset frequency, every check path and the tick extremes
        pending_reqs.push_back(make_req(32'd5, 32'd1234, 1'b0, 1'b1));
        pending_reqs.push_back(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0));
        pending_reqs.push_back(make_req(32'd2, 32'd50, 1'b1, 1'b0));
        pending_reqs.push_back(make_req(32'd3, 32'd51, 1'b1, 1'b1));
        pending_reqs.push_back(make_req(32'd8, 32'd52, 1'b1, 1'b1));
        pending_reqs.push_back(make_req(32'hFFFF_FFFF, 32'd53, 1'b1, 1'b1));
        pending_reqs.push_back(make_req(32'h8000_0000, 32'd54, 1'b1, 1'b0));
        foreach (freqs[k])
            if (k < 6)
                pending_reqs.push_back(make_req((k < 2) ? k : k + 2, 32'd7 * k, 1'b1, 1'b0));
        pending_reqs.push_back(make_req(32'd0, 32'd0, 1'b1, 1'b1));
        pending_reqs.push_back(make_req(32'd1, 32'hFFFF_FFFF, 1'b1, 1'b1));
        pending_reqs.push_back(make_req(32'd4, 32'd99, 1'b1, 1'b1));
        pending_reqs.push_back(make_req(32'd5, 32'd100, 1'b1, 1'b1));
        pending_reqs.push_back(make_req(32'd6, 32'd101, 1'b1, 1'b1));
        pending_reqs.push_back(make_req(32'd7, 32'h8000_0000, 1'b1, 1'b1));
        pending_reqs.push_back(make_req(32'd0, 32'd12345, 1'b1, 1'b1));
        wait_idle();

        foreach (freqs[k])
        begin
            write_frequency(freqs[k]);
            queue_random(110);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_reads.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_reads.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ttc_pkg.sv
hdl/ttc_div.sv
hdl/tick_to_timespec_clock_read.sv
tb/tb.sv
